### rtl/mmts_pkg.sv
// Shared types and constants for the march memory test sequencer.
`default_nettype none

package mmts_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned CountW = 13;
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  // Register byte addresses, decoded on paddr[2] only.
  localparam logic RegBaseAddress = 1'b0;
  localparam logic RegWordCount = 1'b1;

  localparam logic [AddrW-1:0] BaseReset = 32'h2000_0030;
  localparam logic [CountW-1:0] CountReset = 13'd4096;

  typedef struct packed {
    logic        start_req;
    logic [31:0] read_data;
  } item_t;

  typedef struct packed {
    logic        write_enable;
    logic [31:0] write_address;
    logic [31:0] write_data;
    logic [31:0] next_address;
    logic        compared;
    logic        done_res;
    logic        failed;
  } res_t;

endpackage

`default_nettype wire

### rtl/mmts_if.sv
// Valid/ready channel interfaces for the sequencer's item and result streams.
`default_nettype none

interface mmts_in_if;
  logic            valid;
  logic            ready;
  mmts_pkg::item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface mmts_out_if;
  logic           valid;
  logic           ready;
  mmts_pkg::res_t res;

  modport source (output valid, output res, input ready);
  modport sink (input valid, input res, output ready);
endinterface

`default_nettype wire

### rtl/mmts_cfg_regs.sv
// APB-style configuration registers: base address and word count.
`default_nettype none

module mmts_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mmts_pkg::PaddrW-1:0]    paddr,
  input  wire logic [mmts_pkg::PdataW-1:0]    pwdata,
  output logic      [mmts_pkg::PdataW-1:0]    prdata,
  output logic                                pready,
  output logic      [mmts_pkg::AddrW-1:0]     base_address_o,
  output logic      [mmts_pkg::CountW-1:0]    word_count_o
);

  logic [mmts_pkg::AddrW-1:0]  base_address_q;
  logic [mmts_pkg::CountW-1:0] word_count_q;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_address_q <= mmts_pkg::BaseReset;
      word_count_q <= mmts_pkg::CountReset;
    end else if (wr_en) begin
      unique case (paddr[2])
        mmts_pkg::RegBaseAddress: base_address_q <= pwdata;
        mmts_pkg::RegWordCount: word_count_q <= pwdata[mmts_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mmts_pkg::RegBaseAddress: prdata = base_address_q;
      mmts_pkg::RegWordCount: prdata = mmts_pkg::PdataW'(word_count_q);
      default: prdata = '0;
    endcase
  end

  assign base_address_o = base_address_q;
  assign word_count_o = word_count_q;

endmodule

`default_nettype wire

### rtl/march_memory_test_sequencer.sv
// Top level of the four-element march memory test sequencer.
//
//   Channel   Dir  Handshake              Payload
//   item_i    in   valid/ready            start_req, read_data
//   result_o  out  valid/ready            write_enable .. failed
//   cfg       in   psel/penable/pwrite    base_address (0x0), word_count (0x4)
//
// One item is taken per cycle while ready is high; its result is registered on result_o.
// The march state (element, word index, fail flag) updates in the cycle the item is taken.
// A two-entry output buffer keeps input ready while one result waits; ready drops only
// when both entries are full. Reset clears the march state and loads register defaults.
`default_nettype none

module march_memory_test_sequencer #(
  parameter int unsigned MAX_WORDS = 4096,
  parameter int unsigned DATA_BITS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  mmts_in_if.sink                          item_i,
  mmts_out_if.source                       result_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mmts_pkg::PaddrW-1:0] paddr,
  input  wire logic [mmts_pkg::PdataW-1:0] pwdata,
  output logic      [mmts_pkg::PdataW-1:0] prdata,
  output logic                             pready
);

  localparam int unsigned CntW = $clog2(MAX_WORDS + 1);
  localparam int unsigned IdxW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam logic [63:0] OnesPat = {64{1'b1}} >> (64 - DATA_BITS);

  typedef enum logic [2:0] {
    ElemWr0    = 3'd0,
    ElemRd0Wr1 = 3'd1,
    ElemRd1Wr0 = 3'd2,
    ElemRd0    = 3'd3,
    ElemDone   = 3'd4
  } elem_e;

  logic [mmts_pkg::AddrW-1:0]  base_address;
  logic [mmts_pkg::CountW-1:0] word_count;

  mmts_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .base_address_o (base_address),
    .word_count_o   (word_count)
  );

  // March state
  elem_e            elem_q, elem_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             fail_q, fail_d;

  // Output buffer: main entry drives the port, skid entry catches one more result.
  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  mmts_pkg::res_t   out_q, out_d;
  mmts_pkg::res_t   skid_q;
  logic             load_skid;

  logic             push, pop;
  mmts_pkg::res_t   res;

  logic [CntW-1:0]  cnt;
  logic [31:0]      wc_ext;
  logic [31:0]      base_al;
  elem_e            elem_s;
  logic [IdxW-1:0]  idx_s;
  logic [IdxW-1:0]  idx_c;
  logic             fail_s;
  logic [CntW:0]    idx_inc;
  logic [63:0]      rd;
  logic [63:0]      expect_pat;
  logic             we, cmp, mismatch;
  logic [63:0]      wd;

  function automatic logic [31:0] addr_of(input elem_e elem, input logic [IdxW-1:0] idx,
                                          input logic [CntW-1:0] count,
                                          input logic [31:0] base);
    logic [31:0] pos;
    pos = 32'(idx);
    if (elem == ElemRd1Wr0 || elem == ElemRd0) begin
      pos = 32'(count) - 32'(idx) - 32'd1;
    end
    if (elem == ElemDone) begin
      return 32'd0;
    end
    return base + (pos << 2);
  endfunction

  assign push = item_i.valid && item_i.ready;
  assign pop = result_o.valid && result_o.ready;
  assign item_i.ready = !skid_valid_q;

  assign wc_ext = 32'(word_count);
  assign base_al = {base_address[31:2], 2'b00};

  // Effective count: zero acts as one, anything past MAX_WORDS is clamped.
  always_comb begin
    if (wc_ext == 32'd0) begin
      cnt = CntW'(1);
    end else if (wc_ext > 32'(MAX_WORDS)) begin
      cnt = CntW'(MAX_WORDS);
    end else begin
      cnt = CntW'(wc_ext);
    end
  end

  always_comb begin
    elem_s = item_i.item.start_req ? ElemWr0 : elem_q;
    idx_s = item_i.item.start_req ? '0 : idx_q;
    fail_s = item_i.item.start_req ? 1'b0 : fail_q;
    // A count lowered mid-test pulls the index back to the last word.
    idx_c = (CntW'(idx_s) >= cnt) ? IdxW'(cnt - CntW'(1)) : idx_s;
    rd = {32'd0, item_i.item.read_data} & OnesPat;

    we = 1'b0;
    cmp = 1'b0;
    wd = '0;
    expect_pat = '0;
    unique case (elem_s)
      ElemWr0: begin
        we = 1'b1;
      end
      ElemRd0Wr1: begin
        cmp = 1'b1;
        we = 1'b1;
        wd = OnesPat;
      end
      ElemRd1Wr0: begin
        cmp = 1'b1;
        expect_pat = OnesPat;
        we = 1'b1;
      end
      ElemRd0: begin
        cmp = 1'b1;
      end
      default: ;
    endcase

    mismatch = cmp && (rd != expect_pat);
    idx_inc = (CntW + 1)'(idx_c) + (CntW + 1)'(1);
    elem_d = elem_s;
    idx_d = idx_c;
    fail_d = fail_s;

    if (elem_s == ElemDone) begin
      elem_d = ElemDone;
    end else if (mismatch) begin
      fail_d = 1'b1;
      elem_d = ElemDone;
      we = 1'b0;
      wd = '0;
    end else if (idx_inc >= (CntW + 1)'(cnt)) begin
      idx_d = '0;
      unique case (elem_s)
        ElemWr0: elem_d = ElemRd0Wr1;
        ElemRd0Wr1: elem_d = ElemRd1Wr0;
        ElemRd1Wr0: elem_d = ElemRd0;
        default: elem_d = ElemDone;
      endcase
    end else begin
      idx_d = IdxW'(idx_inc);
    end

    res.write_enable = we;
    res.write_address = addr_of(elem_s, idx_c, cnt, base_al);
    res.write_data = wd[31:0];
    res.next_address = addr_of(elem_d, idx_d, cnt, base_al);
    res.compared = cmp;
    res.done_res = (elem_d == ElemDone);
    res.failed = fail_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d = out_q;
    load_skid = 1'b0;
    if (skid_valid_q) begin
      if (pop) begin
        out_d = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || pop) begin
      out_valid_d = push;
      if (push) begin
        out_d = res;
      end
    end else if (push) begin
      skid_valid_d = 1'b1;
      load_skid = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_q <= ElemWr0;
      idx_q <= '0;
      fail_q <= 1'b0;
      out_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
      out_q <= '0;
      skid_q <= '0;
    end else begin
      if (push) begin
        elem_q <= elem_d;
        idx_q <= idx_d;
        fail_q <= fail_d;
      end
      out_valid_q <= out_valid_d;
      skid_valid_q <= skid_valid_d;
      out_q <= out_d;
      if (load_skid) begin
        skid_q <= res;
      end
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.res = out_q;

endmodule

`default_nettype wire
